// ----- rtl/core/hfa_pkg.sv -----
`default_nettype none
package hfa_pkg;
    localparam logic [15:0] EXP_MASK  = 16'h7C00;
    localparam logic [15:0] FRAC_MASK = 16'h03FF;
    localparam logic [15:0] HIDDEN    = 16'h0400;
    localparam logic [15:0] QNAN_CODE = 16'h7FFF;
    localparam logic [15:0] NEG_INF   = 16'hFC00;
    localparam logic [15:0] SIGN_MASK = 16'h8000;
    localparam int unsigned DATA_W    = 16;
    localparam int unsigned STAGES    = 4;
endpackage
`default_nettype wire

// ----- rtl/core/half_float_adder_core.sv -----
// Half-precision (binary16) adder, round to nearest even, subnormals flushed to zero,
// NaN results always 0x7FFF. Four-stage pipeline: operand compare/align, add,
// leading-one search, round/pack. One transaction per cycle is accepted while the output
// is not stalled. A stall on m_tready holds every stage.
`default_nettype none
module half_float_adder_core
    import hfa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] addend_a, [31:16] addend_b
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [15:0] sum_result
);
    logic [STAGES-1:0] vld_reg;
    logic              adv;
    assign adv      = !vld_reg[STAGES-1] || m_tready;
    assign s_tready = adv;

    // stage 1: special cases, order, align
    logic [15:0] a, b, big, sml;
    logic        spec1_next;
    logic [15:0] sval1_next;
    logic [4:0]  d;
    logic [4:0]  eb_next;
    logic [24:0] wb_next;
    logic        sub1_next, sgn1_next;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [10:0] ms;
    always_comb begin
        a = s_tdata[15:0];
        b = s_tdata[31:16];
        a_nan = (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
        b_nan = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
        a_inf = (a[14:0] == EXP_MASK[14:0]);
        b_inf = (b[14:0] == EXP_MASK[14:0]);
        spec1_next = 1'b1;
        sval1_next = 16'd0;
        if (a_nan || b_nan) sval1_next = QNAN_CODE;
        else if (a_inf) sval1_next = (b_inf && (a[15] != b[15])) ? QNAN_CODE : a;
        else if (b_inf) sval1_next = b;
        else if (a[14:10] == 5'd0) sval1_next = (b[14:10] == 5'd0) ? 16'd0 : b;
        else if (b[14:10] == 5'd0) sval1_next = a;
        else spec1_next = 1'b0;
        if (a[14:0] >= b[14:0]) begin
            big = a; sml = b;
        end else begin
            big = b; sml = a;
        end
        d = big[14:10] - sml[14:10];
        ms = {1'b1, sml[9:0]};
        // keep 11 + 14 bits: guard plus sticky
        wb_next = (d > 5'd13) ? {24'd0, 1'b1} :
                  (({ms, 14'd0} >> d) | {24'd0, |(({ms, 14'd0} << (5'd25 - d)) & 25'h1FFFFFF) & (d != 0)});
        eb_next   = big[14:10];
        sub1_next = big[15] ^ sml[15];
        sgn1_next = big[15];
        if (d <= 5'd13) wb_next = ({ms, 14'd0} >> d);
    end
    // exactness: at d<=13 the shifted bits beyond 14 fractional fit; sticky otherwise
    logic        spec1_reg, sub1_reg, sgn1_reg;
    logic [15:0] sval1_reg;
    logic [4:0]  eb1_reg;
    logic [10:0] mb1_reg;
    logic [24:0] wb1_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            spec1_reg <= spec1_next; sval1_reg <= sval1_next;
            sub1_reg <= sub1_next; sgn1_reg <= sgn1_next;
            eb1_reg <= eb_next; mb1_reg <= {1'b1, big[9:0]};
            wb1_reg <= wb_next;
        end
    end

    // stage 2: add or subtract
    logic [25:0] sum2_next;
    always_comb begin
        if (sub1_reg) sum2_next = {1'b0, mb1_reg, 14'd0} - {1'b0, wb1_reg};
        else          sum2_next = {1'b0, mb1_reg, 14'd0} + {1'b0, wb1_reg};
    end
    logic        spec2_reg, sgn2_reg;
    logic [15:0] sval2_reg;
    logic [4:0]  eb2_reg;
    logic [25:0] sum2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            spec2_reg <= spec1_reg; sval2_reg <= sval1_reg; sgn2_reg <= sgn1_reg;
            eb2_reg <= eb1_reg; sum2_reg <= sum2_next;
        end
    end

    // stage 3: leading one, normalize
    logic [4:0]  p3;
    logic [25:0] nrm3;
    always_comb begin
        p3 = 5'd0;
        for (int i = 0; i < 26; i++) if (sum2_reg[i]) p3 = 5'(i);
        nrm3 = sum2_reg << (5'd25 - p3);
    end
    logic        spec3_reg, sgn3_reg, zero3_reg;
    logic [15:0] sval3_reg;
    logic [6:0]  e3_reg;
    logic [25:0] nrm3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            spec3_reg <= spec2_reg; sval3_reg <= sval2_reg; sgn3_reg <= sgn2_reg;
            zero3_reg <= (sum2_reg == 26'd0);
            e3_reg <= 7'(eb2_reg) + 7'(p3) - 7'd24;
            nrm3_reg <= nrm3;
        end
    end

    // stage 4: round, pack
    logic [11:0] keep4;
    logic [6:0]  e4;
    logic        rup;
    logic [15:0] res4_next;
    always_comb begin
        rup = nrm3_reg[14] && ((|nrm3_reg[13:0]) || nrm3_reg[15]);
        keep4 = {1'b0, nrm3_reg[25:15]} + 12'(rup);
        e4 = e3_reg;
        if (keep4[11]) begin
            keep4 = keep4 >> 1; e4 = e4 + 7'd1;
        end
        if (spec3_reg) res4_next = sval3_reg;
        else if (zero3_reg) res4_next = 16'd0;
        else if (e4[6]) res4_next = 16'd0;
        else if (e4 >= 7'd31) res4_next = {sgn3_reg, EXP_MASK[14:0]};
        else if (e4 == 7'd0) res4_next = 16'd0;
        else res4_next = {sgn3_reg, e4[4:0], keep4[9:0]};
    end
    logic [15:0] res_reg;
    always_ff @(posedge aclk) begin
        if (adv) res_reg <= res4_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[STAGES-2:0], s_tvalid};
    end
    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = res_reg;
endmodule
`default_nettype wire
